### hdl/olid_pkg.sv
// Package for the ordered list core: payload words, cell control and FSM types.
// No dependencies. Used by olid_cell and ordered_list_insert_delete_core.
package olid_pkg;

  localparam int DataW     = 32;
  localparam int FuncW     = 3;
  localparam int PosW      = 5;
  localparam int StatusW   = 2;
  localparam int OutCntW   = 5;
  localparam int DepthDflt = 16;

  // Request codes
  localparam logic [FuncW-1:0] FUNC_INSERT    = 3'd0;
  localparam logic [FuncW-1:0] FUNC_APPEND    = 3'd1;
  localparam logic [FuncW-1:0] FUNC_DEL_POS   = 3'd2;
  localparam logic [FuncW-1:0] FUNC_DEL_LAST  = 3'd3;
  localparam logic [FuncW-1:0] FUNC_DEL_FIRST = 3'd4;
  localparam logic [FuncW-1:0] FUNC_DEL_ALL   = 3'd5;

  // Status codes
  localparam logic [StatusW-1:0] STAT_OK     = 2'd0;
  localparam logic [StatusW-1:0] STAT_BADPOS = 2'd1;
  localparam logic [StatusW-1:0] STAT_FULL   = 2'd2;
  localparam logic [StatusW-1:0] STAT_NONE   = 2'd3;

  typedef struct packed {
    logic [FuncW-1:0]        func;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [StatusW-1:0]      status;
    logic signed [DataW-1:0] removed_value;
    logic [OutCntW-1:0]      removed_count;
    logic [OutCntW-1:0]      list_size;
  } out_word_t;

  // What every cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,    // keep contents
    CELL_INSERT,  // open a gap at pos: above pos take left neighbor, pos takes value
    CELL_KEEP,    // rotate left, head word re-enters at pos
    CELL_DROP     // rotate left, head word is discarded
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e       mode;
    logic [DataW-1:0] value;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FIN
  } state_e;

endpackage

### hdl/olid_cell.sv
// One storage cell of the ordered list chain: holds a single entry.
// Depends on olid_pkg for the control struct and data width.
module olid_cell #(
  parameter int IdxW = 4,
  parameter int Idx  = 0
) (
  input  logic                          clk_i,
  input  olid_pkg::cell_ctrl_t          ctrl_i,
  input  logic [IdxW-1:0]               pos_i,
  input  logic [olid_pkg::DataW-1:0]    left_i,
  input  logic [olid_pkg::DataW-1:0]    right_i,
  output logic [olid_pkg::DataW-1:0]    data_o
);

  logic [olid_pkg::DataW-1:0] data_q, data_d;
  logic                       at_pos, above_pos;

  assign at_pos    = (IdxW'(Idx) == pos_i);
  assign above_pos = (IdxW'(Idx) > pos_i);

  // Next contents from neighbors or the broadcast word
  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.mode)
      olid_pkg::CELL_HOLD: data_d = data_q;
      olid_pkg::CELL_INSERT: begin
        if (at_pos) begin
          data_d = ctrl_i.value;
        end else if (above_pos) begin
          data_d = left_i;
        end
      end
      olid_pkg::CELL_KEEP: data_d = at_pos ? ctrl_i.value : right_i;
      olid_pkg::CELL_DROP: data_d = right_i;
      default: data_d = data_q;
    endcase
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### hdl/ordered_list_insert_delete_core.sv
// Ordered list core: a chain of DEPTH cells, one entry each, with a small sequencer.
// Insert, append and rejected requests go from the execute state to the finish state,
// then to the output register; delete by position or value rotates the list once.
// Flow: one request at a time, next word accepted the cycle after the result
// is registered; a finished result waits in the output register. Async active-low
// reset empties the list and clears the sequencer; entry contents are not reset.
module ordered_list_insert_delete_core #(
  parameter int DEPTH = olid_pkg::DepthDflt
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  olid_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output olid_pkg::out_word_t out_data_o
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int IdxW = $clog2(DEPTH);
  localparam int CmpW = (CntW > olid_pkg::PosW) ? CntW : olid_pkg::PosW;

  olid_pkg::state_e         state_q, state_d;
  olid_pkg::in_word_t       req_q, req_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [CntW-1:0]          rem_q, rem_d;
  logic [CntW-1:0]          step_q, step_d;
  logic [CmpW-1:0]          tgt_q, tgt_d;
  logic [CntW-1:0]          rcnt_q, rcnt_d;
  logic [olid_pkg::DataW-1:0] rval_q, rval_d;
  logic [olid_pkg::StatusW-1:0] status_q, status_d;
  logic                     out_valid_q, out_valid_d;
  olid_pkg::out_word_t      out_q, out_d;

  olid_pkg::cell_ctrl_t     cell_ctrl;
  logic [IdxW-1:0]          cell_pos;
  logic [olid_pkg::DataW-1:0] cell_data [DEPTH];

  logic [CmpW-1:0]          cnt_x, pos_x, ins_at, del_at, rcnt_x;
  logic [CntW-1:0]          last_idx;
  logic [olid_pkg::DataW-1:0] head;
  logic                     full, out_free, drop;

  assign cnt_x    = CmpW'(count_q);
  assign pos_x    = CmpW'(req_q.position);
  assign rcnt_x   = CmpW'(rcnt_q);
  assign last_idx = count_q - CntW'(1);
  assign head     = cell_data[0];
  assign full     = (count_q == CntW'(DEPTH));
  assign out_free = !out_valid_q || out_ready_i;
  assign ins_at   = (req_q.func == olid_pkg::FUNC_APPEND) ? cnt_x : pos_x;
  assign del_at   = (req_q.func == olid_pkg::FUNC_DEL_LAST) ? (cnt_x - CmpW'(1)) : pos_x;

  // Drop decision for the word leaving the head during a rotation
  always_comb begin
    unique case (req_q.func)
      olid_pkg::FUNC_DEL_POS,
      olid_pkg::FUNC_DEL_LAST:  drop = (CmpW'(step_q) == tgt_q);
      olid_pkg::FUNC_DEL_FIRST: drop = (head == req_q.value) && (rcnt_q == '0);
      olid_pkg::FUNC_DEL_ALL:   drop = (head == req_q.value);
      default:                  drop = 1'b0;
    endcase
  end

  // Sequencer: next state, cell control, result assembly
  always_comb begin
    state_d        = state_q;
    req_d          = req_q;
    count_d        = count_q;
    rem_d          = rem_q;
    step_d         = step_q;
    tgt_d          = tgt_q;
    rcnt_d         = rcnt_q;
    rval_d         = rval_q;
    status_d       = status_q;
    out_d          = out_q;
    out_valid_d    = out_valid_q;
    cell_ctrl.mode  = olid_pkg::CELL_HOLD;
    cell_ctrl.value = req_q.value;
    cell_pos       = '0;
    in_ready_o     = (state_q == olid_pkg::S_IDLE);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      olid_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = olid_pkg::S_EXEC;
        end
      end

      olid_pkg::S_EXEC: begin
        rval_d   = '0;
        rcnt_d   = '0;
        status_d = olid_pkg::STAT_OK;
        rem_d    = count_q;
        step_d   = '0;
        state_d  = olid_pkg::S_FIN;
        unique case (req_q.func)
          olid_pkg::FUNC_INSERT,
          olid_pkg::FUNC_APPEND: begin
            if (ins_at > cnt_x) begin
              status_d = olid_pkg::STAT_BADPOS;
            end else if (full) begin
              status_d = olid_pkg::STAT_FULL;
            end else begin
              cell_ctrl.mode = olid_pkg::CELL_INSERT;
              cell_pos       = ins_at[IdxW-1:0];
              count_d        = count_q + CntW'(1);
            end
          end
          olid_pkg::FUNC_DEL_POS,
          olid_pkg::FUNC_DEL_LAST: begin
            if (count_q == '0) begin
              status_d = olid_pkg::STAT_NONE;
            end else if (del_at >= cnt_x) begin
              status_d = olid_pkg::STAT_BADPOS;
            end else begin
              tgt_d   = del_at;
              state_d = olid_pkg::S_SCAN;
            end
          end
          olid_pkg::FUNC_DEL_FIRST,
          olid_pkg::FUNC_DEL_ALL: begin
            if (count_q == '0) begin
              status_d = olid_pkg::STAT_NONE;
            end else begin
              state_d = olid_pkg::S_SCAN;
            end
          end
          default: status_d = olid_pkg::STAT_BADPOS;
        endcase
      end

      // One entry per cycle leaves the head and re-enters at the tail unless dropped
      olid_pkg::S_SCAN: begin
        if (rem_q == '0) begin
          status_d = (rcnt_q == '0) ? olid_pkg::STAT_NONE : olid_pkg::STAT_OK;
          state_d  = olid_pkg::S_FIN;
        end else begin
          rem_d           = rem_q - CntW'(1);
          step_d          = step_q + CntW'(1);
          cell_pos        = last_idx[IdxW-1:0];
          cell_ctrl.value = head;
          if (drop) begin
            cell_ctrl.mode = olid_pkg::CELL_DROP;
            count_d        = last_idx;
            rcnt_d         = rcnt_q + CntW'(1);
            if (rcnt_q == '0) begin
              rval_d = head;
            end
          end else begin
            cell_ctrl.mode = olid_pkg::CELL_KEEP;
          end
        end
      end

      olid_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.status        = status_q;
          out_d.removed_value = rval_q;
          out_d.removed_count = rcnt_x[olid_pkg::OutCntW-1:0];
          out_d.list_size     = cnt_x[olid_pkg::OutCntW-1:0];
          state_d             = olid_pkg::S_IDLE;
        end
      end

      default: state_d = olid_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olid_pkg::S_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      step_q      <= '0;
      rcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      step_q      <= step_d;
      rcnt_q      <= rcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    tgt_q    <= tgt_d;
    rval_q   <= rval_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [olid_pkg::DataW-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    olid_cell #(
      .IdxW (IdxW),
      .Idx  (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .pos_i   (cell_pos),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[i])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("list count exceeds depth");

  a_scan_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == olid_pkg::S_SCAN) |-> (rem_q <= count_q))
    else $error("scan has more steps left than entries");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == olid_pkg::S_FIN))
    else $error("result word raised outside finish state");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == olid_pkg::S_EXEC))
    else $error("accepted word not executed");

endmodule
